// ===== design/pmul_pkg.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier package
// Shared sizes, operation codes and control structures of the polynomial
// multiplier core.
// ----------------------------------------------------------------------------
`default_nettype none

package pmul_pkg;

   // Largest number of coefficients of either polynomial.
   localparam int MAX_TERMS  = 16;
   // Width of one Q8.8 coefficient.
   localparam int COEFF_BITS = 16;
   // Width of one full product of two coefficients.
   localparam int PROD_BITS  = 2 * COEFF_BITS;
   // Width of a product coefficient (Q.16 sum).
   localparam int SUM_BITS   = 36;
   // Width of the degree field of a product coefficient.
   localparam int DEG_BITS   = 7;
   // Index into the coefficient store and the accumulator chain.
   localparam int IDX_BITS   = $clog2(MAX_TERMS);
   // Counter that can also hold MAX_TERMS itself.
   localparam int LEN_BITS   = $clog2(MAX_TERMS + 1);

   // Operation carried by an input word.
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_STREAM = 1'b1
   } op_type;

   // Controls from the sequencer to the multiply-accumulate chain.
   typedef struct packed {
      logic                coef_clear;
      logic                coef_write;
      logic [IDX_BITS-1:0] coef_index;
      logic                mac_enable;
      logic                sum_clear;
      logic                sum_shift;
   } chain_ctrl_type;

endpackage

`default_nettype wire

// ===== design/pmul_req_if.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier request channel
// Valid/ready channel that carries coefficient words into the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmul_req_if import pmul_pkg::*;;

   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COEFF_BITS-1:0] coeff;
   logic                         last;

   modport source (output valid, output op, output coeff, output last, input ready);
   modport sink (input valid, input op, input coeff, input last, output ready);

endinterface

`default_nettype wire

// ===== design/pmul_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier response channel
// Valid/ready channel that carries product coefficients out of the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface pmul_rsp_if import pmul_pkg::*;;

   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] product_coeff;
   logic [DEG_BITS-1:0]        degree;
   logic                       last_res;

   modport source (output valid, output product_coeff, output degree, output last_res,
                   input ready);
   modport sink (input valid, input product_coeff, input degree, input last_res,
                 output ready);

endinterface

`default_nettype wire

// ===== design/pmul_mac_chain.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier accumulator chain
// Coefficient store of the first polynomial and a transposed multiply-
// accumulate chain with one multiplier per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module pmul_mac_chain import pmul_pkg::*; (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire chain_ctrl_type               ctrl,
   input  wire logic signed [COEFF_BITS-1:0] coeff,
   output logic signed [SUM_BITS-1:0]        tap0_sum,
   output logic signed [SUM_BITS-1:0]        head_sum
);

   logic signed [COEFF_BITS-1:0] coef_ff [MAX_TERMS];
   logic signed [COEFF_BITS-1:0] coef_in [MAX_TERMS];
   logic signed [SUM_BITS-1:0]   sum_ff  [MAX_TERMS];
   logic signed [SUM_BITS-1:0]   sum_in  [MAX_TERMS];
   logic signed [PROD_BITS-1:0]  prod    [MAX_TERMS];
   logic signed [SUM_BITS-1:0]   prod_ext [MAX_TERMS];

   // One multiplier per lane: the incoming coefficient times each stored one.
   always_comb begin
      for (int i = 0; i < MAX_TERMS; i++) begin
         prod[i]     = coef_ff[i] * coeff;
         prod_ext[i] = SUM_BITS'(prod[i]);
      end
   end

   // The lowest lane finishes the product coefficient of the current degree.
   assign tap0_sum = sum_ff[0] + prod_ext[0];
   assign head_sum = sum_ff[0];

   // Coefficient store: cleared when a new load opens, then written in order.
   always_comb begin
      for (int i = 0; i < MAX_TERMS; i++) begin
         coef_in[i] = ctrl.coef_clear ? '0 : coef_ff[i];
      end
      if (ctrl.coef_write) begin
         coef_in[ctrl.coef_index] = coeff;
      end
   end

   // Partial sums move down one lane per accumulate or flush step.
   always_comb begin
      for (int i = 0; i < MAX_TERMS; i++) begin
         sum_in[i] = sum_ff[i];
      end
      if (ctrl.sum_clear) begin
         for (int i = 0; i < MAX_TERMS; i++) begin
            sum_in[i] = '0;
         end
      end else if (ctrl.mac_enable) begin
         for (int i = 0; i < MAX_TERMS - 1; i++) begin
            sum_in[i] = sum_ff[i+1] + prod_ext[i+1];
         end
         sum_in[MAX_TERMS-1] = '0;
      end else if (ctrl.sum_shift) begin
         for (int i = 0; i < MAX_TERMS - 1; i++) begin
            sum_in[i] = sum_ff[i+1];
         end
         sum_in[MAX_TERMS-1] = '0;
      end
   end

   // State registers; reset leaves the zero polynomial and empty sums.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_TERMS; i++) begin
         if (reset) begin
            coef_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end else begin
            coef_ff[i] <= coef_in[i];
            sum_ff[i]  <= sum_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/polynomial_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier core
// Dense polynomial product in Q8.8 with exact Q.16 coefficients.
// ----------------------------------------------------------------------------
// A stream word's product coefficient is registered and valid in the cycle after the word is taken.
// Throughput: one word per cycle while the response register is free and no flush is running.
// The closing stream word starts a flush of the remaining n-1 partial sums (n = first
// polynomial length), during which no request word is taken; load words give no response.
// Reset (synchronous) clears the first polynomial to zero and all partial sums.
`default_nettype none

module polynomial_multiplier_core import pmul_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   pmul_req_if.sink    req_chan,
   pmul_rsp_if.source  rsp_chan
);

   // Sequencer state.
   logic                load_closed_ff, load_closed_in;
   logic [LEN_BITS-1:0] first_len_ff, first_len_in;
   logic [LEN_BITS-1:0] second_len_ff, second_len_in;
   logic [DEG_BITS-1:0] out_degree_ff, out_degree_in;
   logic [IDX_BITS-1:0] flush_cnt_ff, flush_cnt_in;

   // Response register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_BITS-1:0] product_ff, product_in;
   logic [DEG_BITS-1:0]        degree_ff, degree_in;
   logic                       last_res_ff, last_res_in;

   logic                       out_free;
   logic                       flush_busy;
   logic                       accept;
   logic                       load_acc;
   logic                       stream_acc;
   logic [LEN_BITS-1:0]        load_index;
   logic [LEN_BITS-1:0]        second_len_next;
   logic [IDX_BITS-1:0]        tail_count;
   logic                       finish;
   logic                       load_result;
   chain_ctrl_type             ctrl;
   logic signed [SUM_BITS-1:0] tap0_sum;
   logic signed [SUM_BITS-1:0] head_sum;

   pmul_mac_chain u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .coeff    (req_chan.coeff),
      .tap0_sum (tap0_sum),
      .head_sum (head_sum)
   );

   // Handshake: the response register frees up as its word is taken.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign flush_busy     = (flush_cnt_ff != '0);
   assign req_chan.ready = !flush_busy && out_free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign load_acc       = accept && (req_chan.op == OP_LOAD);
   assign stream_acc     = accept && (req_chan.op == OP_STREAM);

   // Load bookkeeping and stream termination.
   assign load_index      = load_closed_ff ? '0 : first_len_ff;
   assign second_len_next = second_len_ff + LEN_BITS'(1);
   assign finish          = req_chan.last || (second_len_next >= LEN_BITS'(MAX_TERMS));
   assign tail_count      = (first_len_ff == '0) ? '0
                          : IDX_BITS'(first_len_ff - LEN_BITS'(1));

   // Chain control.
   always_comb begin
      ctrl            = '0;
      ctrl.coef_index = load_index[IDX_BITS-1:0];
      if (load_acc) begin
         ctrl.coef_clear = load_closed_ff;
         ctrl.coef_write = (load_index < LEN_BITS'(MAX_TERMS));
         ctrl.sum_clear  = (second_len_ff != '0);
      end else if (stream_acc) begin
         ctrl.mac_enable = 1'b1;
      end else if (flush_busy && out_free) begin
         ctrl.sum_shift = 1'b1;
      end
   end

   // Next state of the sequencer.
   always_comb begin
      load_closed_in = load_closed_ff;
      first_len_in   = first_len_ff;
      second_len_in  = second_len_ff;
      out_degree_in  = out_degree_ff;
      flush_cnt_in   = flush_cnt_ff;
      if (load_acc) begin
         if (second_len_ff != '0) begin
            second_len_in = '0;
            out_degree_in = '0;
         end
         if (ctrl.coef_write) begin
            first_len_in = load_index + LEN_BITS'(1);
         end else begin
            first_len_in = load_index;
         end
         load_closed_in = req_chan.last;
      end else if (stream_acc) begin
         load_closed_in = 1'b1;
         if (finish && (tail_count == '0)) begin
            second_len_in = '0;
            out_degree_in = '0;
         end else begin
            second_len_in = second_len_next;
            out_degree_in = out_degree_ff + DEG_BITS'(1);
         end
         if (finish) begin
            flush_cnt_in = tail_count;
         end
      end else if (flush_busy && out_free) begin
         flush_cnt_in = flush_cnt_ff - IDX_BITS'(1);
         if (flush_cnt_ff == IDX_BITS'(1)) begin
            second_len_in = '0;
            out_degree_in = '0;
         end else begin
            out_degree_in = out_degree_ff + DEG_BITS'(1);
         end
      end
   end

   // Response register loading.
   always_comb begin
      load_result = 1'b0;
      product_in  = product_ff;
      degree_in   = degree_ff;
      last_res_in = last_res_ff;
      if (stream_acc) begin
         load_result = 1'b1;
         product_in  = tap0_sum;
         degree_in   = out_degree_ff;
         last_res_in = finish && (tail_count == '0);
      end else if (flush_busy && out_free) begin
         load_result = 1'b1;
         product_in  = head_sum;
         degree_in   = out_degree_ff;
         last_res_in = (flush_cnt_ff == IDX_BITS'(1));
      end
      if (load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_closed_ff <= 1'b1;
         first_len_ff   <= '0;
         second_len_ff  <= '0;
         out_degree_ff  <= '0;
         flush_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         load_closed_ff <= load_closed_in;
         first_len_ff   <= first_len_in;
         second_len_ff  <= second_len_in;
         out_degree_ff  <= out_degree_in;
         flush_cnt_ff   <= flush_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      degree_ff   <= degree_in;
      last_res_ff <= last_res_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.product_coeff = product_ff;
   assign rsp_chan.degree        = degree_ff;
   assign rsp_chan.last_res      = last_res_ff;

endmodule

`default_nettype wire

// ===== design/pmul_checker.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier checker
// Port-level assertions on the polynomial multiplier core, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmul_checker import pmul_pkg::*; (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_op,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic signed [SUM_BITS-1:0] rsp_product_coeff,
   input wire logic [DEG_BITS-1:0]        rsp_degree,
   input wire logic                       rsp_last_res
);

   // A stalled response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_product_coeff)
         && $stable(rsp_degree) && $stable(rsp_last_res))
      else $error("stalled response word changed");

   // Every stream word yields a response word in the next cycle.
   a_stream_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_STREAM) |=> rsp_valid)
      else $error("stream word produced no response");

   // A load word into a free response slot yields no response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_LOAD) && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("load word produced a response");

   // During a flush every non-final taken word is followed by another one.
   a_flush_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_res && !req_ready |=> rsp_valid)
      else $error("flush stopped before the final coefficient");

endmodule

bind polynomial_multiplier_core pmul_checker u_pmul_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_op            (req_chan.op),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_product_coeff (rsp_chan.product_coeff),
   .rsp_degree        (rsp_chan.degree),
   .rsp_last_res      (rsp_chan.last_res)
);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Polynomial multiplier core testbench
// Feeds load and stream words for the first and second polynomial through the
// request channel and checks every product coefficient that comes back
// against a cycle-free predictor of the convolution. The test starts with a
// short directed sequence and then runs random phases. These phases cover no
// idling, sender gaps, receiver stalls, both together, and a long receiver
// hold-off that backs the core up.
// ----------------------------------------------------------------------------
module tb;
   import pmul_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_WORDS     = 90;
   localparam int SETTLE_CYCLES   = 40;
   localparam int MAX_PRINTED     = 50;

   // One request word and one product coefficient.
   typedef struct {
      op_type                       op;
      logic signed [COEFF_BITS-1:0] coeff;
      logic                         last;
   } coeff_word_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] value;
      logic [DEG_BITS-1:0] degree;
      logic                last_res;
   } product_coeff_type;

   logic clock;
   logic reset;

   pmul_req_if req_bus ();
   pmul_rsp_if rsp_bus ();

   polynomial_multiplier_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   coeff_word_type    words_to_send [$];
   product_coeff_type product_coeffs_due [$];

   int   mismatch_count = 0;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold       = 1'b0;
   logic hold_arm       = 1'b0;
   logic extreme_run    = 1'b0;

   // Predictor state: first polynomial, open load and the running product.
   logic signed [COEFF_BITS-1:0] poly_a [MAX_TERMS];
   int                           poly_a_len = 0;
   logic                         load_open  = 1'b0;
   logic [63:0]                  partial_sums [MAX_TERMS];
   int                           next_degree = 0;
   int                           b_taken     = 0;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Mismatch reporting: one line per failure, printing capped.
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < MAX_PRINTED) begin
         $display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void drop_product();
      for (int i = 0; i < MAX_TERMS; i++) begin
         partial_sums[i] = '0;
      end
      next_degree = 0;
      b_taken     = 0;
   endfunction

   // Predictor state after reset: zero first polynomial, no open load.
   function automatic void reset_predictor();
      for (int i = 0; i < MAX_TERMS; i++) begin
         poly_a[i] = '0;
      end
      poly_a_len = 0;
      load_open  = 1'b0;
      drop_product();
   endfunction

   // Convolution predictor: one accepted word in, due product coefficients out.
   function automatic void predict_word(op_type op, logic signed [COEFF_BITS-1:0] c,
                                        logic fin);
      int          n;
      logic [63:0] s0;
      logic        closing;
      if (op == OP_LOAD) begin
         if (b_taken != 0) begin
            drop_product();
         end
         // A load word after a closed load starts a fresh first polynomial.
         if (!load_open) begin
            for (int i = 0; i < MAX_TERMS; i++) begin
               poly_a[i] = '0;
            end
            poly_a_len = 0;
            load_open  = 1'b1;
         end
         if (poly_a_len < MAX_TERMS) begin
            poly_a[poly_a_len] = c;
            poly_a_len++;
         end
         if (fin) begin
            load_open = 1'b0;
         end
      end else begin
         load_open = 1'b0;
         n = (poly_a_len == 0) ? 1 : poly_a_len;
         s0 = partial_sums[0] + longint'(poly_a[0]) * longint'(c);
         for (int i = 0; i + 1 < n; i++) begin
            partial_sums[i] = partial_sums[i+1] + longint'(poly_a[i+1]) * longint'(c);
         end
         partial_sums[n-1] = '0;
         b_taken++;
         closing = fin || (b_taken >= MAX_TERMS);
         product_coeffs_due.push_back('{s0[SUM_BITS-1:0], DEG_BITS'(next_degree),
                                        closing && (n == 1)});
         next_degree++;
         // The closing word flushes the rest of the accumulator chain.
         if (closing) begin
            for (int i = 0; i + 1 < n; i++) begin
               product_coeffs_due.push_back('{partial_sums[i][SUM_BITS-1:0],
                                              DEG_BITS'(next_degree), (i + 2) == n});
               next_degree++;
            end
            drop_product();
         end
      end
   endfunction

   // Request driver: holds a word until it is taken, then picks the next one.
   always @(posedge clock) begin : req_driver
      coeff_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.op    <= OP_LOAD;
         req_bus.coeff <= '0;
         req_bus.last  <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = words_to_send.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.op    <= w.op;
            req_bus.coeff <= w.coeff;
            req_bus.last  <= w.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready with random stalls and the long hold-off.
   always @(posedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Hold-off: the receiver stays away while the sender keeps offering words.
   initial begin : rsp_hold_off
      wait (hold_arm);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Monitor: predicts on accepted request words, checks accepted responses.
   always @(posedge clock) begin : product_monitor
      product_coeff_type want;
      if (reset) begin
         reset_predictor();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_word(op_type'(req_bus.op), req_bus.coeff, req_bus.last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (product_coeffs_due.size() == 0) begin
               report_mismatch("unexpected product coefficient, degree",
                               64'(rsp_bus.degree), 64'(0));
            end else begin
               want = product_coeffs_due.pop_front();
               if (rsp_bus.product_coeff !== want.value) begin
                  report_mismatch("product_coeff", 64'(rsp_bus.product_coeff),
                                  64'(want.value));
               end
               if (rsp_bus.degree !== want.degree) begin
                  report_mismatch("degree", 64'(rsp_bus.degree), 64'(want.degree));
               end
               if (rsp_bus.last_res !== want.last_res) begin
                  report_mismatch("last_res", 64'(rsp_bus.last_res), 64'(want.last_res));
               end
            end
         end
      end
   end

   // Stimulus helpers.
   function automatic logic signed [COEFF_BITS-1:0] pick_coeff();
      if (extreme_run) begin
         return 16'sh8000;
      end
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return COEFF_BITS'($urandom);
      endcase
   endfunction

   task automatic queue_word(op_type op, logic signed [COEFF_BITS-1:0] c, logic last);
      words_to_send.push_back('{op, c, last});
   endtask

   task automatic queue_load(int len, logic close);
      for (int i = 0; i < len; i++) begin
         queue_word(OP_LOAD, pick_coeff(), close && (i == len - 1));
      end
   endtask

   task automatic queue_stream(int len, logic close);
      for (int i = 0; i < len; i++) begin
         queue_word(OP_STREAM, pick_coeff(), close && (i == len - 1));
      end
   endtask

   // Mostly well-formed load/stream runs, with overlong and broken ones mixed in.
   task automatic queue_random_phase(int target);
      int start;
      int kind;
      start = words_to_send.size();
      while (words_to_send.size() - start < target) begin
         kind = $urandom_range(99);
         if (kind < 4) begin
            // Full-size product with the largest coefficient sums.
            extreme_run = 1'b1;
            queue_load(MAX_TERMS, 1'b1);
            queue_stream(MAX_TERMS, 1'b1);
            extreme_run = 1'b0;
         end else if (kind < 70) begin
            queue_load($urandom_range(1, MAX_TERMS), 1'b1);
            repeat ($urandom_range(1, 3)) queue_stream($urandom_range(1, MAX_TERMS), 1'b1);
         end else if (kind < 80) begin
            // Second polynomial at least as long as the chain: closes on its own.
            queue_load($urandom_range(1, MAX_TERMS), 1'b1);
            queue_stream($urandom_range(MAX_TERMS, MAX_TERMS + 4), 1'b0);
         end else if (kind < 87) begin
            // Too many load words; the extra ones are ignored.
            queue_load($urandom_range(MAX_TERMS + 1, MAX_TERMS + 4), 1'b1);
            queue_stream($urandom_range(1, MAX_TERMS), 1'b1);
         end else if (kind < 94) begin
            // Stream words arrive while the load is still open.
            queue_load($urandom_range(1, 6), 1'b0);
            queue_stream($urandom_range(1, MAX_TERMS), 1'b1);
         end else begin
            // Unfinished product, usually dropped by the next load.
            queue_stream($urandom_range(1, MAX_TERMS - 1), 1'b0);
         end
      end
   endtask

   task automatic wait_drained();
      while (words_to_send.size() != 0 || req_bus.valid || product_coeffs_due.size() != 0)
         @(posedge clock);
   endtask

   // Main sequence.
   initial begin : stimulus
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Before any load the first polynomial is zero of length one.
      queue_word(OP_STREAM, 16'sh7FFF, 1'b0);
      queue_word(OP_STREAM, 16'sh8000, 1'b1);
      // Extreme coefficients on both sides.
      queue_word(OP_LOAD, 16'sh8000, 1'b0);
      queue_word(OP_LOAD, 16'sh7FFF, 1'b0);
      queue_word(OP_LOAD, 16'sh8000, 1'b1);
      queue_word(OP_STREAM, 16'sh8000, 1'b0);
      queue_word(OP_STREAM, 16'sh8000, 1'b0);
      queue_word(OP_STREAM, 16'sh7FFF, 1'b1);
      // A stream word closes a load that is still open.
      queue_word(OP_LOAD, 16'sh0100, 1'b0);
      queue_word(OP_LOAD, 16'shFF00, 1'b0);
      queue_word(OP_STREAM, 16'sh0080, 1'b0);
      // A new load drops the unfinished product.
      queue_word(OP_LOAD, 16'sh0001, 1'b1);
      queue_word(OP_STREAM, 16'shFFFF, 1'b1);
      // Single-coefficient polynomials.
      queue_word(OP_LOAD, 16'sh1234, 1'b1);
      queue_word(OP_STREAM, 16'sh8000, 1'b1);
      queue_random_phase(PHASE_WORDS);
      wait_drained();

      send_idle_pct = 56;
      queue_random_phase(PHASE_WORDS);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 56;
      queue_random_phase(PHASE_WORDS);
      wait_drained();

      send_idle_pct  = 13;
      recv_stall_pct = 13;
      queue_random_phase(PHASE_WORDS);
      wait_drained();

      // Back-pressure: receiver holds off while words keep coming.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random_phase(PHASE_WORDS);
      hold_arm = 1'b1;
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (product_coeffs_due.size() != 0) begin
         report_mismatch("product coefficients never returned",
                         64'(0), 64'(product_coeffs_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog.
   initial begin : watchdog
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
design/pmul_pkg.sv
design/pmul_req_if.sv
design/pmul_rsp_if.sv
design/pmul_mac_chain.sv
design/polynomial_multiplier_core.sv
design/pmul_checker.sv
tb/tb.sv
